// ===== rtl/core/cdamd_pkg.sv =====
// Shared constants, types and character table for the display mode detector.
package cdamd_pkg;

  localparam int unsigned FRAME_BYTES = 8;
  localparam int unsigned TEXT_BYTES  = FRAME_BYTES - 1;
  localparam int unsigned LEN_W       = 4;
  localparam int unsigned ID_W        = 11;
  localparam int unsigned WIN_W       = 16;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WATCH_ID    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAIR_WINDOW = 1'd1;

  localparam logic [ID_W-1:0]  WATCH_ID_RST = 11'd0;
  localparam logic [WIN_W-1:0] WINDOW_RST   = 16'd100;

  localparam logic [7:0] HEAD_MARK    = 8'h10;
  localparam logic [7:0] TEXT_MARK    = 8'h21;
  localparam logic [7:0] ASCII_FORMAT = 8'h59;

  typedef enum logic [3:0] {
    CH_A, CH_U, CH_X, CH_R, CH_E, CH_N, CH_L, CH_T, CH_C, CH_GT, CH_M
  } ch_t;

  localparam int unsigned CHAR_COUNT = 11;

  function automatic logic [7:0] char_of(ch_t c);
    logic [7:0] v;
    v = 8'h00;
    case (c)
      CH_A:    v = "A";
      CH_U:    v = "U";
      CH_X:    v = "X";
      CH_R:    v = "R";
      CH_E:    v = "E";
      CH_N:    v = "N";
      CH_L:    v = "L";
      CH_T:    v = "T";
      CH_C:    v = "C";
      CH_GT:   v = ">";
      CH_M:    v = "M";
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic                  dig;
    logic                  sp;
    logic [CHAR_COUNT-1:0] eq;
  } cls_t;

  typedef struct packed {
    logic hit;
    logic mode;
  } decision_t;

endpackage

// ===== rtl/core/cdamd_if.sv =====
// Item channel interfaces: CAN frame input and mode result output.
interface cdamd_in_if;
  logic                              valid;
  logic                              ready;
  logic [cdamd_pkg::ID_W-1:0]        frame_id;
  logic [cdamd_pkg::LEN_W-1:0]       frame_len;
  logic [7:0]                        data_byte0;
  logic [7:0]                        data_byte1;
  logic [7:0]                        data_byte2;
  logic [7:0]                        data_byte3;
  logic [7:0]                        data_byte4;
  logic [7:0]                        data_byte5;
  logic [7:0]                        data_byte6;
  logic [7:0]                        data_byte7;
  logic [cdamd_pkg::TIME_W-1:0]      now_ms;

  modport source (
    output valid, frame_id, frame_len, data_byte0, data_byte1, data_byte2, data_byte3,
           data_byte4, data_byte5, data_byte6, data_byte7, now_ms,
    input  ready
  );
  modport sink (
    input  valid, frame_id, frame_len, data_byte0, data_byte1, data_byte2, data_byte3,
           data_byte4, data_byte5, data_byte6, data_byte7, now_ms,
    output ready
  );
endinterface

interface cdamd_out_if;
  logic valid;
  logic ready;
  logic aux_mode;

  modport source (output valid, aux_mode, input ready);
  modport sink (input valid, aux_mode, output ready);
endinterface

// ===== rtl/core/cdamd_lane.sv =====
// Per-byte character classifier lane.
module cdamd_lane (
  input  logic [7:0]      byte_i,
  output cdamd_pkg::cls_t cls_o
);

  assign cls_o.dig = (byte_i >= "0") && (byte_i <= "9");
  assign cls_o.sp  = (byte_i == " ");

  for (genvar k = 0; k < cdamd_pkg::CHAR_COUNT; k++) begin : g_eq
    assign cls_o.eq[k] = (byte_i == cdamd_pkg::char_of(cdamd_pkg::ch_t'(k)));
  end

endmodule

// ===== rtl/core/cdamd_merge.sv =====
// Combines lane classes into a pattern decision: a hit on any pattern, and the AUX mode.
module cdamd_merge (
  input  cdamd_pkg::cls_t      cls_i [cdamd_pkg::TEXT_BYTES],
  input  logic [7:0]           fmt_i,
  output cdamd_pkg::decision_t dec_o
);

  logic p_aux, p_banner, p_cd, p_radio, p_mpre, p_lpre, p_freq;
  logic fmt_ascii;

  assign fmt_ascii = (fmt_i >= cdamd_pkg::ASCII_FORMAT);

  // cls_i[0] is data byte 1
  assign p_aux = cls_i[0].eq[cdamd_pkg::CH_A] && cls_i[1].eq[cdamd_pkg::CH_U]
              && cls_i[2].eq[cdamd_pkg::CH_X];

  assign p_banner = cls_i[0].eq[cdamd_pkg::CH_R] && cls_i[1].eq[cdamd_pkg::CH_E]
                 && cls_i[2].eq[cdamd_pkg::CH_N] && cls_i[3].eq[cdamd_pkg::CH_A]
                 && cls_i[4].eq[cdamd_pkg::CH_U] && cls_i[5].eq[cdamd_pkg::CH_L]
                 && cls_i[6].eq[cdamd_pkg::CH_T];

  assign p_cd = cls_i[0].eq[cdamd_pkg::CH_T] && cls_i[1].eq[cdamd_pkg::CH_R]
             && cls_i[2].sp && (cls_i[3].sp || cls_i[3].dig) && cls_i[4].dig
             && cls_i[5].sp && cls_i[6].eq[cdamd_pkg::CH_C];

  assign p_radio = cls_i[0].eq[cdamd_pkg::CH_GT] && cls_i[1].sp && !cls_i[2].sp
                && fmt_ascii;

  assign p_mpre = cls_i[0].eq[cdamd_pkg::CH_M] && cls_i[1].sp
               && (cls_i[2].sp || cls_i[2].dig) && cls_i[3].dig && cls_i[4].dig
               && cls_i[5].dig && cls_i[6].sp;

  assign p_lpre = cls_i[0].eq[cdamd_pkg::CH_L] && cls_i[1].sp && cls_i[2].sp
               && cls_i[3].dig && cls_i[4].dig && cls_i[5].dig && cls_i[6].sp;

  assign p_freq = cls_i[0].sp && cls_i[1].sp && cls_i[2].sp && cls_i[3].dig
               && cls_i[4].dig && cls_i[5].dig && cls_i[6].dig && !fmt_ascii;

  assign dec_o.hit  = p_aux || p_banner || p_cd || p_radio || p_mpre || p_lpre || p_freq;
  assign dec_o.mode = p_aux;

endmodule

// ===== rtl/core/can_display_aux_mode_detector.sv =====
// Top level: frame filter, header state, window test and result buffer.
//
// Usage: one CAN frame enters per item on in_if (valid/ready). Frames whose
// id differs from watch_id or whose length is below eight are dropped.
// Header frames latch the format byte and arrival time; text frames within
// pair_window_ms of the last header are matched by seven byte lanes and a
// merge stage. A result item on out_if carries the new aux_mode, and only
// when the mode changes.
// Throughput: one frame per cycle while the skid entry is free; all decoding
// is a single combinational pass between the input handshake and the result
// register.
// Output: a result register plus one skid entry; input ready drops only
// while the skid entry is occupied, so a stalled receiver blocks input
// after one further result-producing frame.
// Reset (rst_n low, synchronous): watch_id 0, window 100 ms, no header seen,
// mode not AUX, result buffer empty. Configuration via cfg_we, cfg_idx and
// cfg_wdata: the user writes it only while the block is idle; no check enforces it.
module can_display_aux_mode_detector (
  input  logic                             clk,
  input  logic                             rst_n,
  cdamd_in_if.sink                         in_if,
  cdamd_out_if.source                      out_if,
  input  logic                             cfg_we,
  input  logic [cdamd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [cdamd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [cdamd_pkg::ID_W-1:0]   watch_id_r;
  logic [cdamd_pkg::WIN_W-1:0]  window_r;
  logic [7:0]                   format_byte_r;
  logic [cdamd_pkg::TIME_W-1:0] header_time_r;
  logic                         header_seen_r;
  logic                         aux_active_r;
  logic                         out_valid_r, out_mode_r;
  logic                         skid_valid_r, skid_mode_r;

  logic                         accept, frame_ok, is_head, is_text, late, emit, out_free;
  logic [cdamd_pkg::TIME_W-1:0] deadline, diff;
  logic [7:0]                   text_bytes [cdamd_pkg::TEXT_BYTES];
  cdamd_pkg::cls_t              cls [cdamd_pkg::TEXT_BYTES];
  cdamd_pkg::decision_t         dec;

  assign in_if.ready = !skid_valid_r;
  assign accept      = in_if.valid && !skid_valid_r;

  assign frame_ok = (in_if.frame_id == watch_id_r)
                 && (in_if.frame_len >= cdamd_pkg::LEN_W'(cdamd_pkg::FRAME_BYTES));
  assign is_head  = frame_ok && (in_if.data_byte0 == cdamd_pkg::HEAD_MARK);
  assign is_text  = frame_ok && (in_if.data_byte0 == cdamd_pkg::TEXT_MARK);

  assign deadline = header_time_r + cdamd_pkg::TIME_W'(window_r);
  assign diff     = in_if.now_ms - deadline;
  assign late     = (diff != '0) && !diff[cdamd_pkg::TIME_W-1];

  assign text_bytes[0] = in_if.data_byte1;
  assign text_bytes[1] = in_if.data_byte2;
  assign text_bytes[2] = in_if.data_byte3;
  assign text_bytes[3] = in_if.data_byte4;
  assign text_bytes[4] = in_if.data_byte5;
  assign text_bytes[5] = in_if.data_byte6;
  assign text_bytes[6] = in_if.data_byte7;

  for (genvar i = 0; i < cdamd_pkg::TEXT_BYTES; i++) begin : g_lane
    cdamd_lane u_lane (
      .byte_i (text_bytes[i]),
      .cls_o  (cls[i])
    );
  end

  cdamd_merge u_merge (
    .cls_i (cls),
    .fmt_i (format_byte_r),
    .dec_o (dec)
  );

  assign emit = accept && is_text && header_seen_r && !late && dec.hit
             && (dec.mode != aux_active_r);

  assign out_free = !out_valid_r || out_if.ready;

  assign out_if.valid    = out_valid_r;
  assign out_if.aux_mode = out_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      watch_id_r    <= cdamd_pkg::WATCH_ID_RST;
      window_r      <= cdamd_pkg::WINDOW_RST;
      header_time_r <= '0;
      header_seen_r <= 1'b0;
      aux_active_r  <= 1'b0;
      out_valid_r   <= 1'b0;
      skid_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          cdamd_pkg::CFG_WATCH_ID:    watch_id_r <= cfg_wdata[cdamd_pkg::ID_W-1:0];
          cdamd_pkg::CFG_PAIR_WINDOW: window_r   <= cfg_wdata[cdamd_pkg::WIN_W-1:0];
          default: ;
        endcase
      end
      if (accept && is_head) begin
        header_time_r <= in_if.now_ms;
        header_seen_r <= 1'b1;
      end
      if (emit) begin
        aux_active_r <= dec.mode;
      end
      if (out_free) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= emit;
        end
      end else if (emit) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (accept && is_head) begin
      format_byte_r <= in_if.data_byte6;
    end
    if (out_free) begin
      out_mode_r <= skid_valid_r ? skid_mode_r : dec.mode;
    end else if (emit) begin
      skid_mode_r <= dec.mode;
    end
  end

endmodule
